### rtl/core/mdf_pkg.sv
// Package for the message duplicate filter.
// Types, status codes, register indexes and constants shared by all mdf modules.
package mdf_pkg;

    localparam logic [31:0] HASH_SEED    = 32'd5381;
    localparam int          HASH_SHIFT   = 5;
    localparam int          CFG_IDX_W    = 8;
    localparam int          CFG_DATA_W   = 32;
    localparam int          WINDOW_W     = 16;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd60;

    localparam logic [CFG_IDX_W-1:0] CFG_STORAGE_ONLINE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SECONDS = 8'd1;

    typedef enum logic [1:0] {
        ST_ACCEPTED  = 2'd0,
        ST_DUPLICATE = 2'd1,
        ST_OFFLINE   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_LAST
    } t_back_state;

    typedef struct packed {
        logic [31:0] hash;
        logic [31:0] now;
    } t_chk_req;

    typedef struct packed {
        logic                storage_online;
        logic [WINDOW_W-1:0] window_seconds;
    } t_cfg;

endpackage

### rtl/core/mdf_front.sv
// Front end: accepts characters and folds them into the running hash.
// Pushes (hash ^ ric, time) check requests into the queue; uses mdf_pkg.
module mdf_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [7:0]       i_char_byte,
    input  logic             i_has_char,
    input  logic             i_end_of_message,
    input  logic [31:0]      i_ric_code,
    input  logic [31:0]      i_now_seconds,
    input  logic             i_q_full,
    output logic             o_push,
    output mdf_pkg::t_chk_req o_push_data
);
    import mdf_pkg::*;

    logic [31:0] r_hash;
    logic [31:0] n_hash;
    logic [31:0] mixed;
    logic        accept;

    assign busy   = i_q_full;
    assign accept = start & ~i_q_full;
    assign mixed  = i_has_char ? (((r_hash << HASH_SHIFT) + r_hash) ^ {24'd0, i_char_byte})
                               : r_hash;

    always_comb begin
        n_hash = r_hash;
        if (accept) begin
            n_hash = i_end_of_message ? HASH_SEED : mixed;
        end
    end

    assign o_push           = accept & i_end_of_message;
    assign o_push_data.hash = mixed ^ i_ric_code;
    assign o_push_data.now  = i_now_seconds;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= HASH_SEED;
        end else begin
            r_hash <= n_hash;
        end
    end

endmodule

### rtl/core/mdf_queue.sv
// Two-entry queue of check requests between front and back end.
// Uses mdf_pkg for the request type.
module mdf_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mdf_pkg::t_chk_req i_push_data,
    output logic              o_full,
    output logic              o_empty,
    input  logic              i_pop,
    output mdf_pkg::t_chk_req o_pop_data
);
    import mdf_pkg::*;

    t_chk_req   r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_full     = (r_count == 2'd2);
    assign o_empty    = (r_count == 2'd0);
    assign do_push    = i_push & ~o_full;
    assign do_pop     = i_pop & ~o_empty;
    assign o_pop_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

### rtl/core/mdf_back.sv
// Back end: scans the recent-slot memory one entry per cycle, decides status,
// records accepted hashes round robin and drives the result strobe; uses mdf_pkg.
module mdf_back #(
    parameter int SLOT_COUNT = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mdf_pkg::t_cfg     i_cfg,
    input  logic              i_q_empty,
    output logic              o_pop,
    input  mdf_pkg::t_chk_req i_req,
    output logic              o_valid,
    output logic [1:0]        o_status,
    output logic [31:0]       o_message_hash
);
    import mdf_pkg::*;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    logic [31:0] mem_hash [SLOT_COUNT];
    logic [31:0] mem_time [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_slot_vld;

    t_back_state r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [IDX_W-1:0] r_next, n_next;
    logic [31:0] r_h, n_h;
    logic [31:0] r_now, n_now;
    logic        r_dup, n_dup;
    logic        r_chk, n_chk;
    logic [31:0] r_rd_hash;
    logic [31:0] r_rd_time;
    logic        r_rd_vld;
    logic        r_valid, n_valid;
    t_status     r_status, n_status;
    logic [31:0] r_out_hash, n_out_hash;

    logic [31:0] slot_hash_q;
    logic [31:0] slot_time_q;
    logic [31:0] age;
    logic        match;
    logic        rd_en;
    logic        wr_en;

    assign slot_hash_q = r_rd_vld ? r_rd_hash : 32'd0;
    assign slot_time_q = r_rd_vld ? r_rd_time : 32'd0;
    assign age         = r_now - slot_time_q;
    assign match       = r_chk && (slot_hash_q == r_h)
                         && (age[31] || (age <= {16'd0, i_cfg.window_seconds}));

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_next     = r_next;
        n_h        = r_h;
        n_now      = r_now;
        n_dup      = r_dup;
        n_chk      = 1'b0;
        n_valid    = 1'b0;
        n_status   = r_status;
        n_out_hash = r_out_hash;
        o_pop      = 1'b0;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_q_empty) begin
                    o_pop = 1'b1;
                    n_h   = i_req.hash;
                    n_now = i_req.now;
                    if (!i_cfg.storage_online) begin
                        n_valid    = 1'b1;
                        n_status   = ST_OFFLINE;
                        n_out_hash = i_req.hash;
                    end else begin
                        n_idx   = '0;
                        n_dup   = 1'b0;
                        n_state = BK_SCAN;
                    end
                end
            end
            BK_SCAN: begin
                rd_en = 1'b1;
                n_chk = 1'b1;
                n_dup = r_dup | match;
                if (r_idx == LAST_IDX) begin
                    n_state = BK_LAST;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            BK_LAST: begin
                n_valid    = 1'b1;
                n_out_hash = r_h;
                if (r_dup | match) begin
                    n_status = ST_DUPLICATE;
                end else begin
                    n_status = ST_ACCEPTED;
                    wr_en    = 1'b1;
                    n_next   = (r_next == LAST_IDX) ? '0 : r_next + 1'b1;
                end
                n_state = BK_IDLE;
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_hash[r_next] <= r_h;
            mem_time[r_next] <= r_now;
        end
        if (rd_en) begin
            r_rd_hash <= mem_hash[r_idx];
            r_rd_time <= mem_time[r_idx];
            r_rd_vld  <= r_slot_vld[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BK_IDLE;
            r_idx      <= '0;
            r_next     <= '0;
            r_dup      <= 1'b0;
            r_chk      <= 1'b0;
            r_valid    <= 1'b0;
            r_slot_vld <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_next  <= n_next;
            r_dup   <= n_dup;
            r_chk   <= n_chk;
            r_valid <= n_valid;
            if (wr_en) begin
                r_slot_vld[r_next] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_h        <= n_h;
        r_now      <= n_now;
        r_status   <= n_status;
        r_out_hash <= n_out_hash;
    end

    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_message_hash = r_out_hash;

endmodule

### rtl/core/message_dedup_filter_top.sv
// Top level of the message duplicate filter: configuration registers and
// wiring of mdf_front, mdf_queue and mdf_back; uses mdf_pkg.
//
//   channel   | handshake                 | payload
//   ----------+---------------------------+---------------------------------------
//   input     | start / busy              | char_byte has_char end_of_message ric now
//   result    | o_valid strobe, 1 cycle   | status message_hash
//   config    | i_cfg_valid / o_cfg_ready | i_cfg_index i_cfg_data
//
// A character item is folded into the running hash in the front end. An end item queues a check
// that the back end runs as a scan of the slot memory, one slot memory read per cycle,
// then the decision and slot write; offline checks are answered from the idle state with no scan.
// busy is high while the two-entry check queue is full.
// Synchronous active-low reset; slot memory entries read as zero until written.
// The result strobe cannot be held off by the receiver.
module message_dedup_filter_top #(
    parameter int SLOT_COUNT = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [7:0]                         i_char_byte,
    input  logic                               i_has_char,
    input  logic                               i_end_of_message,
    input  logic [31:0]                        i_ric_code,
    input  logic [31:0]                        i_now_seconds,
    output logic                               o_valid,
    output logic [1:0]                         o_status,
    output logic [31:0]                        o_message_hash,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [mdf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mdf_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import mdf_pkg::*;

    t_cfg     r_cfg;
    logic     cfg_wr;
    logic     q_full;
    logic     q_empty;
    logic     push;
    logic     pop;
    t_chk_req push_data;
    t_chk_req pop_data;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid & o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.storage_online <= 1'b0;
            r_cfg.window_seconds <= WINDOW_RESET;
        end else if (cfg_wr) begin
            if (i_cfg_index == CFG_STORAGE_ONLINE) begin
                r_cfg.storage_online <= i_cfg_data[0];
            end
            if (i_cfg_index == CFG_WINDOW_SECONDS) begin
                r_cfg.window_seconds <= i_cfg_data[WINDOW_W-1:0];
            end
        end
    end

    mdf_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_char_byte      (i_char_byte),
        .i_has_char       (i_has_char),
        .i_end_of_message (i_end_of_message),
        .i_ric_code       (i_ric_code),
        .i_now_seconds    (i_now_seconds),
        .i_q_full         (q_full),
        .o_push           (push),
        .o_push_data      (push_data)
    );

    mdf_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (q_full),
        .o_empty     (q_empty),
        .i_pop       (pop),
        .o_pop_data  (pop_data)
    );

    mdf_back #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_q_empty      (q_empty),
        .o_pop          (pop),
        .i_req          (pop_data),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_message_hash (o_message_hash)
    );

endmodule

### verif/mdf_checker.sv
`timescale 1ns / 1ps
// Scoreboard for message_dedup_filter_top: follows input, config and result transfers,
// predicts status and hash for each message end, and compares results in order.
// Depends on mdf_pkg.
module mdf_checker #(
    parameter int SLOT_COUNT = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_busy,
    input  logic [7:0]                     i_char_byte,
    input  logic                           i_has_char,
    input  logic                           i_end_of_message,
    input  logic [31:0]                    i_ric_code,
    input  logic [31:0]                    i_now_seconds,
    input  logic                           i_valid,
    input  logic [1:0]                     i_status,
    input  logic [31:0]                    i_message_hash,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [mdf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mdf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);
    import mdf_pkg::*;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    typedef struct packed {
        t_status     status;
        logic [31:0] hash;
    } t_verdict;

    t_verdict            verdicts_due[$];
    logic                online;
    logic [WINDOW_W-1:0] window;
    logic [31:0]         msg_hash;
    logic [31:0]         seen_hash [SLOT_COUNT];
    logic [31:0]         seen_time [SLOT_COUNT];
    logic [IDX_W-1:0]    wr_slot;
    int                  fails = 0;

    function automatic logic [31:0] fold_char(input logic [31:0] h, input logic [7:0] c);
        return ((h << HASH_SHIFT) + h) ^ {24'd0, c};
    endfunction

    // age is read as signed: a stored time in the future always counts as recent
    function automatic logic is_recent(input logic [31:0] now_s, input logic [31:0] then_s,
                                       input logic [WINDOW_W-1:0] win);
        logic [31:0] age;
        age = now_s - then_s;
        return age[31] || (age <= {{(32-WINDOW_W){1'b0}}, win});
    endfunction

    always @(posedge i_clk) begin : score
        t_verdict    want;
        logic [31:0] h;
        logic        dup;
        if (!i_rst_n) begin
            online   = 1'b0;
            window   = WINDOW_RESET;
            msg_hash = HASH_SEED;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                seen_hash[i] = '0;
                seen_time[i] = '0;
            end
            wr_slot = '0;
            verdicts_due.delete();
        end else begin
            if (i_valid) begin
                if (verdicts_due.size() == 0) begin
                    $error("unexpected result: status %0d, message_hash %h",
                           i_status, i_message_hash);
                    fails++;
                end else begin
                    want = verdicts_due.pop_front();
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, i_status);
                        fails++;
                    end
                    if (i_message_hash !== want.hash) begin
                        $error("message_hash: expected %h, actual %h",
                               want.hash, i_message_hash);
                        fails++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_STORAGE_ONLINE: online = i_cfg_data[0];
                    CFG_WINDOW_SECONDS: window = i_cfg_data[WINDOW_W-1:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy) begin
                if (i_has_char)
                    msg_hash = fold_char(msg_hash, i_char_byte);
                if (i_end_of_message) begin
                    h         = msg_hash ^ i_ric_code;
                    msg_hash  = HASH_SEED;
                    want.hash = h;
                    if (!online) begin
                        want.status = ST_OFFLINE;
                    end else begin
                        dup = 1'b0;
                        for (int i = 0; i < SLOT_COUNT; i++) begin
                            if (seen_hash[i] == h && is_recent(i_now_seconds, seen_time[i], window))
                                dup = 1'b1;
                        end
                        if (dup) begin
                            want.status = ST_DUPLICATE;
                        end else begin
                            seen_hash[wr_slot] = h;
                            seen_time[wr_slot] = i_now_seconds;
                            wr_slot            = (wr_slot == LAST_IDX) ? '0 : wr_slot + 1'b1;
                            want.status        = ST_ACCEPTED;
                        end
                    end
                    verdicts_due.push_back(want);
                end
            end
        end
        o_pending    <= verdicts_due.size();
        o_fail_count <= fails;
    end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// Testbench top for message_dedup_filter_top: clock, reset, directed and random
// message traffic with config changes between phases, and the final verdict.
// Depends on mdf_pkg, mdf_checker and the RTL.
module tb;
    import mdf_pkg::*;

    localparam int SLOT_COUNT    = 8;
    localparam int SETTLE_CYCLES = 2 * (SLOT_COUNT + 2) + 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int ITEM_TARGET   = 1100;
    localparam int PHASES        = 8;
    localparam int POOL_SIZE     = 6;
    localparam int MAX_CHARS     = 8;

    logic                  i_clk            = 1'b0;
    logic                  i_rst_n          = 1'b0;
    logic                  start            = 1'b0;
    logic                  busy;
    logic [7:0]            i_char_byte      = '0;
    logic                  i_has_char       = 1'b0;
    logic                  i_end_of_message = 1'b0;
    logic [31:0]           i_ric_code       = '0;
    logic [31:0]           i_now_seconds    = '0;
    logic                  o_valid;
    logic [1:0]            o_status;
    logic [31:0]           o_message_hash;
    logic                  i_cfg_valid      = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index      = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data       = '0;

    int          fail_count;
    int          pending;
    int          cycles     = 0;
    int          sent_items = 0;
    int          cur_window = 60;
    logic [31:0] clock_s    = '0;
    logic [7:0]  pool_chars [POOL_SIZE][MAX_CHARS];
    int          pool_len   [POOL_SIZE];
    logic [31:0] pool_ric   [POOL_SIZE];

    message_dedup_filter_top #(.SLOT_COUNT(SLOT_COUNT)) uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_char_byte      (i_char_byte),
        .i_has_char       (i_has_char),
        .i_end_of_message (i_end_of_message),
        .i_ric_code       (i_ric_code),
        .i_now_seconds    (i_now_seconds),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_message_hash   (o_message_hash),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    mdf_checker #(.SLOT_COUNT(SLOT_COUNT)) dedup_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_char_byte      (i_char_byte),
        .i_has_char       (i_has_char),
        .i_end_of_message (i_end_of_message),
        .i_ric_code       (i_ric_code),
        .i_now_seconds    (i_now_seconds),
        .i_valid          (o_valid),
        .i_status         (o_status),
        .i_message_hash   (o_message_hash),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("message_dedup_filter_top test failed");
            $finish;
        end
    end

    task automatic send_item(input logic [7:0] ch, input logic with_char, input logic at_end,
                             input logic [31:0] ric, input logic [31:0] now_s);
        start            <= 1'b1;
        i_char_byte      <= ch;
        i_has_char       <= with_char;
        i_end_of_message <= at_end;
        i_ric_code       <= ric;
        i_now_seconds    <= now_s;
        if (with_char || at_end)
            sent_items++;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic maybe_idle(input int gap_pct);
        if ($urandom_range(0, 99) < gap_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
    endtask

    // hold off until every pending result is out and the back end has gone quiet
    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic set_mode(input logic online, input logic [15:0] win);
        logic [31:0]          junk;
        logic [CFG_IDX_W-1:0] stray;
        junk       = $urandom;
        stray      = CFG_IDX_W'($urandom_range(2, 255));
        cur_window = int'(win);
        if ($urandom_range(0, 1) == 1) begin
            cfg_write(CFG_STORAGE_ONLINE, {junk[31:1], online});
            cfg_write(CFG_WINDOW_SECONDS, {junk[31:16], win});
        end else begin
            cfg_write(CFG_WINDOW_SECONDS, {junk[31:16], win});
            cfg_write(CFG_STORAGE_ONLINE, {junk[31:1], online});
        end
        if ($urandom_range(0, 2) == 0)
            cfg_write(stray, $urandom);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic void new_message(input int slot);
        pool_len[slot] = $urandom_range(0, MAX_CHARS);
        for (int i = 0; i < MAX_CHARS; i++)
            pool_chars[slot][i] = 8'($urandom);
        case ($urandom_range(0, 7))
            0:       pool_ric[slot] = '0;
            1:       pool_ric[slot] = '1;
            default: pool_ric[slot] = $urandom;
        endcase
    endfunction

    function automatic void tick_clock();
        case ($urandom_range(0, 9))
            0:       clock_s = $urandom;
            1:       clock_s = clock_s - $urandom_range(0, 50);
            2, 3:    clock_s = clock_s + $urandom_range(0, 2 * cur_window + 2);
            default: clock_s = clock_s + $urandom_range(0, 40);
        endcase
    endfunction

    task automatic send_message(input int slot, input logic [31:0] ric, input int gap_pct);
        int   n;
        logic char_on_end;
        n           = pool_len[slot];
        char_on_end = (n > 0) && ($urandom_range(0, 1) == 1);
        for (int i = 0; i < n - char_on_end; i++) begin
            if ($urandom_range(0, 15) == 0) begin
                send_item(8'($urandom), 1'b0, 1'b0, $urandom, $urandom);
                maybe_idle(gap_pct);
            end
            send_item(pool_chars[slot][i], 1'b1, 1'b0, $urandom, $urandom);
            maybe_idle(gap_pct);
        end
        // truncated message: its hash runs on into whatever follows
        if ($urandom_range(0, 19) == 0)
            return;
        if (char_on_end)
            send_item(pool_chars[slot][n-1], 1'b1, 1'b1, ric, clock_s);
        else
            send_item(8'($urandom), 1'b0, 1'b1, ric, clock_s);
        maybe_idle(gap_pct);
    endtask

    initial begin
        int          slot;
        int          roll;
        int          gap_pct;
        logic        online;
        logic [15:0] win;
        logic [31:0] ric;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset config: storage offline, zero byte hashed
        send_item(8'h00, 1'b1, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(8'hFF, 1'b1, 1'b0, 32'h0, 32'h0);
        send_item(8'h41, 1'b1, 1'b1, 32'h0, 32'h0);
        settle();
        cfg_write(CFG_STORAGE_ONLINE, 32'd1);
        i_cfg_valid <= 1'b0;
        // empty messages hashing to zero hit the cleared slots; window edge at 60
        send_item(8'hA5, 1'b0, 1'b1, HASH_SEED, 32'd60);
        send_item(8'h00, 1'b0, 1'b1, HASH_SEED, 32'd61);
        send_item(8'h5A, 1'b0, 1'b0, 32'h0, 32'h0);
        send_item(8'h00, 1'b0, 1'b1, HASH_SEED, 32'd0);
        send_item(8'h78, 1'b1, 1'b0, 32'h0, 32'h0);
        send_item(8'h79, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(8'h78, 1'b1, 1'b0, 32'h0, 32'h0);
        send_item(8'h79, 1'b1, 1'b0, 32'h0, 32'h0);
        send_item(8'h00, 1'b0, 1'b1, 32'hFFFF_FFFF, 32'd5);
        settle();
        cfg_write(CFG_WINDOW_SECONDS, 32'd0);
        cfg_write(8'hFF, 32'hFFFF_FFFF);
        i_cfg_valid <= 1'b0;
        for (int k = 0; k < 3; k++) begin
            send_item(8'h78, 1'b1, 1'b0, 32'h0, 32'h0);
            send_item(8'h79, 1'b1, 1'b1, 32'hFFFF_FFFF, (k == 2) ? 32'd5 : 32'd6);
        end
        settle();
        set_mode(1'b0, 16'hFFFF);
        send_item(8'h00, 1'b0, 1'b1, 32'h0, 32'h0);

        for (int p = 0; p < POOL_SIZE; p++)
            new_message(p);
        for (int phase = 0; phase < PHASES; phase++) begin
            settle();
            online = ($urandom_range(0, 7) != 0);
            case (phase % 4)
                0:       win = 16'($urandom);
                1:       win = 16'hFFFF;
                2:       win = 16'($urandom_range(0, 120));
                default: win = 16'h0000;
            endcase
            set_mode(online, win);
            gap_pct = (phase == PHASES - 1 || phase % 3 == 1) ? 0 : 20;
            while (sent_items < ITEM_TARGET * (phase + 1) / PHASES) begin
                roll = $urandom_range(0, 99);
                if (roll < 8) begin
                    send_item(8'($urandom), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), $urandom, $urandom);
                    maybe_idle(gap_pct);
                end else begin
                    slot = $urandom_range(0, POOL_SIZE - 1);
                    if (roll < 30)
                        new_message(slot);
                    ric = ($urandom_range(0, 6) == 0) ? $urandom : pool_ric[slot];
                    tick_clock();
                    send_message(slot, ric, gap_pct);
                end
            end
        end
        settle();

        if (fail_count == 0 && pending == 0)
            $display("message_dedup_filter_top test passed");
        else
            $display("message_dedup_filter_top test failed");
        $finish;
    end

endmodule

### sim.f
rtl/core/mdf_pkg.sv
rtl/core/mdf_front.sv
rtl/core/mdf_queue.sv
rtl/core/mdf_back.sv
rtl/core/message_dedup_filter_top.sv
verif/mdf_checker.sv
verif/tb.sv
